FILE: rtl/fpb_pkg.sv
// Shared types, codes and arithmetic helpers of the framebuffer pixel blender.
`default_nettype none

package fpb_pkg;

    localparam int FUNC_W  = 2;
    localparam int POS_W   = 16;
    localparam int COMP_W  = 8;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 8;

    // Component lanes of a pixel: red in the low byte, alpha in the high byte.
    localparam int CH_ALPHA  = 3;
    localparam int NUM_COLOR = 3;

    typedef logic [3:0][COMP_W-1:0] t_pixel;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_SWAP  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        BM_OVERWRITE  = 2'd0,
        BM_ALPHA_OVER = 2'd1,
        BM_SAT_ADD    = 2'd2,
        BM_MULTIPLY   = 2'd3
    } t_blend_mode;

    typedef enum logic [CIDX_W-1:0] {
        CFG_BLEND_MODE   = 3'd0,
        CFG_CLIP_ENABLE  = 3'd1,
        CFG_CLIP_LEFT    = 3'd2,
        CFG_CLIP_TOP     = 3'd3,
        CFG_CLIP_SPAN_X  = 3'd4,
        CFG_CLIP_SPAN_Y  = 3'd5,
        CFG_FRAME_WIDTH  = 3'd6,
        CFG_FRAME_HEIGHT = 3'd7
    } t_cfg_reg;

    localparam logic [7:0] CLIP_SPAN_X_RST  = 8'd128;
    localparam logic [6:0] CLIP_SPAN_Y_RST  = 7'd64;
    localparam logic [7:0] FRAME_WIDTH_RST  = 8'd128;
    localparam logic [6:0] FRAME_HEIGHT_RST = 7'd64;

    // Reciprocal of 255 scaled by 2^23, rounded up; exact for every 16-bit operand.
    localparam logic [16:0] RECIP_255 = 17'd32897;

    typedef struct packed {
        logic        start;
        t_blend_mode mode;
        t_pixel      src;
        t_pixel      dst;
    } t_blend_req;

    typedef struct packed {
        logic   done;
        t_pixel pix;
    } t_blend_rsp;

    // floor(x / 255) for x up to 255 * 255
    function automatic logic [COMP_W-1:0] div255(input logic [15:0] x);
        logic [32:0] prod;
        prod = 33'(x) * 33'(RECIP_255);
        return prod[30:23];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fpb_channels.sv
// Channel interfaces of the framebuffer pixel blender: command in, pixel out, register write.
`default_nettype none

interface fpb_pix_in_if;
    import fpb_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [COMP_W-1:0]        src_red;
    logic [COMP_W-1:0]        src_green;
    logic [COMP_W-1:0]        src_blue;
    logic [COMP_W-1:0]        src_alpha;
    modport source (output valid, func, pos_x, pos_y, src_red, src_green, src_blue,
                    src_alpha, input ready);
    modport sink   (input valid, func, pos_x, pos_y, src_red, src_green, src_blue,
                    src_alpha, output ready);
endinterface

interface fpb_pix_out_if;
    import fpb_pkg::*;
    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] out_red;
    logic [COMP_W-1:0] out_green;
    logic [COMP_W-1:0] out_blue;
    logic [COMP_W-1:0] out_alpha;
    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface fpb_cfg_if;
    import fpb_pkg::*;
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/fpb_frame_mem.sv
// Frame store: both buffers in one synchronous RAM, one write and one registered read port.
`default_nettype none

module fpb_frame_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/fpb_blend.sv
// Blend unit: products, per-mode combine, and a three-lane restoring divider for alpha-over.
`default_nettype none

module fpb_blend (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fpb_pkg::t_blend_req i_req,
    output fpb_pkg::t_blend_rsp      o_rsp
);
    import fpb_pkg::*;

    typedef enum logic [3:0] {
        BS_IDLE = 4'b0001,
        BS_SUM  = 4'b0010,
        BS_DIV  = 4'b0100,
        BS_DONE = 4'b1000
    } t_bstate;

    t_bstate r_state, n_state;

    logic [15:0]       r_s;
    logic [7:0]        r_nsa;
    logic [15:0]       r_pa  [NUM_COLOR];
    logic [15:0]       r_pd  [NUM_COLOR];
    logic [15:0]       r_pm  [4];
    logic [23:0]       r_num [NUM_COLOR];
    logic [23:0]       r_dvs;
    logic [7:0]        r_quo [NUM_COLOR];
    logic [2:0]        r_cnt;
    t_pixel            r_res;

    logic [8:0]        w_sat [NUM_COLOR];
    logic              w_ge  [NUM_COLOR];

    always_comb begin
        for (int k = 0; k < NUM_COLOR; k++) begin
            w_sat[k] = 9'(i_req.dst[k]) + 9'(i_req.src[k]);
            w_ge[k]  = (r_num[k] >= r_dvs);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_req.start) begin
                    n_state = BS_SUM;
                end
            end
            BS_SUM: begin
                if (i_req.mode == BM_ALPHA_OVER && r_s != 16'd0) begin
                    n_state = BS_DIV;
                end else begin
                    n_state = BS_DONE;
                end
            end
            BS_DIV: begin
                if (r_cnt == 3'd0) begin
                    n_state = BS_DONE;
                end
            end
            BS_DONE: begin
                n_state = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                if (i_req.start) begin
                    for (int k = 0; k < NUM_COLOR; k++) begin
                        r_pa[k] <= 16'(i_req.src[k]) * 16'(i_req.src[CH_ALPHA]);
                        r_pd[k] <= 16'(i_req.dst[k]) * 16'(i_req.dst[CH_ALPHA]);
                    end
                    for (int k = 0; k < 4; k++) begin
                        r_pm[k] <= 16'(i_req.dst[k]) * 16'(i_req.src[k]);
                    end
                    r_s   <= ({i_req.src[CH_ALPHA], 8'h00} - 16'(i_req.src[CH_ALPHA]))
                             + 16'(i_req.dst[CH_ALPHA])
                             * 16'(8'hFF - i_req.src[CH_ALPHA]);
                    r_nsa <= 8'hFF - i_req.src[CH_ALPHA];
                end
            end
            BS_SUM: begin
                for (int k = 0; k < NUM_COLOR; k++) begin
                    r_num[k] <= ({r_pa[k], 8'h00} - 24'(r_pa[k]))
                                + 24'(r_pd[k]) * 24'(r_nsa);
                    r_quo[k] <= 8'd0;
                end
                r_dvs <= {1'b0, r_s, 7'b0};
                r_cnt <= 3'd7;
                case (i_req.mode)
                    BM_OVERWRITE: begin
                        r_res <= i_req.src;
                    end
                    BM_ALPHA_OVER: begin
                        // colours arrive from the divider; zero when both alphas are zero
                        for (int k = 0; k < NUM_COLOR; k++) begin
                            r_res[k] <= 8'd0;
                        end
                        r_res[CH_ALPHA] <= div255(r_s);
                    end
                    BM_SAT_ADD: begin
                        for (int k = 0; k < NUM_COLOR; k++) begin
                            r_res[k] <= w_sat[k][8] ? 8'hFF : w_sat[k][7:0];
                        end
                        r_res[CH_ALPHA] <= (i_req.dst[CH_ALPHA] > i_req.src[CH_ALPHA])
                                           ? i_req.dst[CH_ALPHA] : i_req.src[CH_ALPHA];
                    end
                    BM_MULTIPLY: begin
                        for (int k = 0; k < 4; k++) begin
                            r_res[k] <= div255(r_pm[k]);
                        end
                    end
                    default: begin
                        r_res <= i_req.src;
                    end
                endcase
            end
            BS_DIV: begin
                // one quotient bit per lane, most significant first
                for (int k = 0; k < NUM_COLOR; k++) begin
                    if (w_ge[k]) begin
                        r_num[k] <= r_num[k] - r_dvs;
                    end
                    r_quo[k] <= {r_quo[k][6:0], w_ge[k]};
                    if (r_cnt == 3'd0) begin
                        r_res[k] <= {r_quo[k][6:0], w_ge[k]};
                    end
                end
                r_dvs <= r_dvs >> 1;
                r_cnt <= r_cnt - 3'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done = (r_state == BS_DONE);
    assign o_rsp.pix  = r_res;

endmodule

`default_nettype wire

FILE: rtl/framebuffer_pixel_blender_top.sv
// Framebuffer pixel blender top level: command decode, bounds and clip checks, sequencing.
//
// Usage: commands enter on i_pix (write, read or swap with a signed position and an
// RGBA source colour); read results leave on o_pix; registers are written on i_cfg,
// which is always ready and must only be used while the block is idle.
// One command is processed at a time. A swap, an unused code, or a write rejected by
// bounds or clip is done at acceptance; a read out of bounds skips the RAM read, and a
// read waits while the output register is full and its value not yet taken.
// A write does a read-modify-write over the frame RAM port; in alpha-over mode it also
// runs the 8-step restoring divider that forms each colour quotient, unless both
// alphas are 0.
// The result of a read waits in an output register; the block keeps accepting
// commands while it waits, and a second read holds until the first is taken.
// After reset the frame RAM is cleared one word a cycle, all 2 * MAX_WIDTH * MAX_HEIGHT
// words (16384 at the defaults), with i_pix.ready low; register writes are taken.
// Reset also selects buffer 0 as the back buffer and loads the register defaults.
`default_nettype none

module framebuffer_pixel_blender_top #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    fpb_pix_in_if.sink    i_pix,
    fpb_pix_out_if.source o_pix,
    fpb_cfg_if.sink       i_cfg
);
    import fpb_pkg::*;

    localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH = 2 * PLANE;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_KICK  = 6'b001000,
        ST_BLEND = 6'b010000,
        ST_RESP  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    t_blend_mode r_blend_mode;
    logic        r_clip_enable;
    logic [6:0]  r_clip_left;
    logic [5:0]  r_clip_top;
    logic [7:0]  r_clip_span_x;
    logic [6:0]  r_clip_span_y;
    logic [7:0]  r_frame_width;
    logic [6:0]  r_frame_height;

    logic          r_back;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_addr;
    logic          r_is_write;
    logic          r_inside;
    t_pixel        r_src;
    logic          r_ov;
    t_pixel        r_out;

    logic [15:0]   w_w, w_h, w_ux, w_uy, w_off;
    logic [8:0]    w_clip_right;
    logic [7:0]    w_clip_bottom;
    logic          w_inside, w_in_clip, w_accept, w_out_free;
    t_pixel        w_src;
    t_blend_req    w_req;
    t_blend_rsp    w_rsp;
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata, w_rdata;

    assign w_w = (16'(r_frame_width) > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH)
                                                       : 16'(r_frame_width);
    assign w_h = (16'(r_frame_height) > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT)
                                                         : 16'(r_frame_height);
    assign w_ux = i_pix.pos_x;
    assign w_uy = i_pix.pos_y;

    assign w_inside = !w_ux[15] && !w_uy[15] && (w_ux < w_w) && (w_uy < w_h);

    assign w_clip_right  = 9'(r_clip_left) + 9'(r_clip_span_x);
    assign w_clip_bottom = 8'(r_clip_top) + 8'(r_clip_span_y);
    assign w_in_clip = !r_clip_enable ||
                       ((w_ux >= 16'(r_clip_left)) && (w_ux < 16'(w_clip_right)) &&
                        (w_uy >= 16'(r_clip_top)) && (w_uy < 16'(w_clip_bottom)));

    // row pitch is the active width; an inside position has x below 256 and y below 128
    assign w_off = 16'(w_uy[6:0]) * 16'(w_w[7:0]) + 16'(w_ux[7:0]);

    assign w_src = {i_pix.src_alpha, i_pix.src_blue, i_pix.src_green, i_pix.src_red};

    assign i_pix.ready = (r_state == ST_IDLE);
    assign w_accept    = i_pix.valid && i_pix.ready;
    assign i_cfg.ready = 1'b1;
    assign w_out_free  = !r_ov || o_pix.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_pix.func)
                        FUNC_WRITE: begin
                            if (w_inside && w_in_clip) begin
                                n_state = ST_READ;
                            end
                        end
                        FUNC_READ: begin
                            n_state = w_inside ? ST_READ : ST_RESP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = r_is_write ? ST_KICK : ST_RESP;
            end
            ST_KICK: begin
                n_state = ST_BLEND;
            end
            ST_BLEND: begin
                if (w_rsp.done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr          <= '0;
            r_back         <= 1'b0;
            r_ov           <= 1'b0;
            r_blend_mode   <= BM_ALPHA_OVER;
            r_clip_enable  <= 1'b0;
            r_clip_left    <= 7'd0;
            r_clip_top     <= 6'd0;
            r_clip_span_x  <= CLIP_SPAN_X_RST;
            r_clip_span_y  <= CLIP_SPAN_Y_RST;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (w_accept && i_pix.func == FUNC_SWAP) begin
                r_back <= ~r_back;
            end
            if (r_state == ST_RESP && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_pix.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_BLEND_MODE:   r_blend_mode   <= t_blend_mode'(i_cfg.data[1:0]);
                    CFG_CLIP_ENABLE:  r_clip_enable  <= i_cfg.data[0];
                    CFG_CLIP_LEFT:    r_clip_left    <= i_cfg.data[6:0];
                    CFG_CLIP_TOP:     r_clip_top     <= i_cfg.data[5:0];
                    CFG_CLIP_SPAN_X:  r_clip_span_x  <= i_cfg.data;
                    CFG_CLIP_SPAN_Y:  r_clip_span_y  <= i_cfg.data[6:0];
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // transaction payload captured at acceptance; read result loaded into the output register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr     <= (r_back ? AW'(PLANE) : AW'(0)) + AW'(w_off);
            r_is_write <= (i_pix.func == FUNC_WRITE);
            r_inside   <= w_inside;
            r_src      <= w_src;
        end
        if (r_state == ST_RESP && w_out_free) begin
            r_out <= r_inside ? t_pixel'(w_rdata) : t_pixel'(32'd0);
        end
    end

    assign w_req.start = (r_state == ST_KICK);
    assign w_req.mode  = r_blend_mode;
    assign w_req.src   = r_src;
    assign w_req.dst   = t_pixel'(w_rdata);

    fpb_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_we    = (r_state == ST_CLEAR) || (r_state == ST_BLEND && w_rsp.done);
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr : r_addr;
    assign w_wdata = (r_state == ST_CLEAR) ? 32'd0 : 32'(w_rsp.pix);
    assign w_re    = (r_state == ST_READ);

    fpb_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign o_pix.valid     = r_ov;
    assign o_pix.out_red   = r_out[0];
    assign o_pix.out_green = r_out[1];
    assign o_pix.out_blue  = r_out[2];
    assign o_pix.out_alpha = r_out[CH_ALPHA];

endmodule

`default_nettype wire
